// ===== rtl/core/sba_pkg.sv =====
// ============================================================================
// Slab block allocator package
// Shared constants, widths, command and status codes and the slab table
// entry type for the slab block allocator.
// ============================================================================
`default_nettype none

package sba_pkg;

   // Sizing of the allocator.
   localparam int MAX_SLABS    = 8;
   localparam int MAX_BLOCKS   = 1024;
   localparam int HEADER_BYTES = 24;
   localparam int PTR_BYTES    = 8;

   // Field widths fixed by the interface.
   localparam int ADDR_W = 48;
   localparam int LEN_W  = 24;
   localparam int SZ_W   = 16;
   localparam int ST_W   = 3;
   localparam int CMD_W  = 2;

   // Derived widths.
   localparam int SLOT_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int SCNT_W = $clog2(MAX_SLABS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int BCNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = SZ_W + BCNT_W;
   localparam int DIV_W  = (PROD_W > LEN_W) ? PROD_W : LEN_W;
   localparam int DCNT_W = $clog2(DIV_W + 1);
   localparam int LIM_W  = ((ADDR_W > PROD_W) ? ADDR_W : PROD_W) + 2;

   // Register index of the block size register; it sits at byte address
   // four times its index.
   localparam logic REG_BLOCK_BYTES = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_GROW  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 3'd0,
      ST_OOM        = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_OVER_FREE  = 3'd3,
      ST_TOO_SMALL  = 3'd4,
      ST_TABLE_FULL = 3'd5,
      ST_MISALIGNED = 3'd6
   } status_type;

   // One slab table entry.
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [BCNT_W-1:0] total;
      logic [BCNT_W-1:0] free_cnt;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  head;
   } slab_entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/slab_block_allocator.sv =====
// Grow divides the slab length by the block size in the shared bit-serial divider
// and then writes one link per new block (up to MAX_BLOCKS) through the one link
// memory write port. Alloc and free search the slabs one by one; free also uses
// the divider. One transaction is processed at a time.
// Reset is synchronous and active high: no slabs, block size 8, no clearing pass.
// ============================================================================
// Slab block allocator
// Fixed-size block allocator over up to MAX_SLABS slabs, with per-slab free
// lists chained through a shared link memory.
// ============================================================================
`default_nettype none

module slab_block_allocator
   import sba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic [LEN_W-1:0]  req_length,

   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ADDR_W-1:0]      rsp_block_address,
   output logic [ST_W-1:0]        rsp_status,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   // The sequencer walks each transaction through these states. Only one
   // transaction is in flight, so the read-modify-write of a link entry and
   // of a slab entry never overlaps with another access to the same entry.
   typedef enum logic [10:0] {
      S_IDLE       = 11'b000_0000_0001,
      S_GROW_DIV   = 11'b000_0000_0010,
      S_GROW_CHAIN = 11'b000_0000_0100,
      S_SEARCH     = 11'b000_0000_1000,
      S_CHECK      = 11'b000_0001_0000,
      S_ALLOC_RD   = 11'b000_0010_0000,
      S_ALLOC_ADD  = 11'b000_0100_0000,
      S_FREE_DIV   = 11'b000_1000_0000,
      S_FREE_UPD   = 11'b001_0000_0000,
      S_DONE       = 11'b010_0000_0000,
      S_GROW_CHK   = 11'b100_0000_0000
   } state_type;

   state_type             state_ff, state_in;

   // Configuration and bookkeeping.
   logic [SZ_W-1:0]       block_bytes_ff, block_bytes_in;
   logic [SCNT_W-1:0]     slab_count_ff, slab_count_in;
   logic [BCNT_W-1:0]     blocks_used_ff, blocks_used_in;

   // The captured transaction.
   cmd_type               cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   // Search and chaining counters.
   logic [SCNT_W-1:0]     kcnt_ff, kcnt_in;
   logic [BCNT_W-1:0]     chain_ff, chain_in;
   logic [BCNT_W-1:0]     grow_n_ff, grow_n_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // Bit-serial restoring divider, one quotient bit per cycle. The dividend
   // register shifts out at the top and collects quotient bits at the bottom.
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [SZ_W-1:0]       rem_ff, rem_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [SZ_W:0]         rem_sh;
   logic                  rem_ge;
   logic [SZ_W:0]         rem_diff;

   // Result held until the output register is free.
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   status_type            rsp_status_ff, rsp_status_in;

   // Slab table: eight entries in flip-flops, read at the current slot.
   slab_entry_type        slab_tab [MAX_SLABS];
   logic                  tab_we;
   logic [SLOT_W-1:0]     tab_wslot;
   slab_entry_type        tab_wdata;

   // Link memory, one read and one write port, registered read data.
   logic [IDX_W-1:0]      link_mem [MAX_BLOCKS];
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [IDX_W-1:0]      mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [IDX_W-1:0]      link_rdata_ff;

   // Helper values.
   logic [SZ_W-1:0]       eff_sz;
   logic [SLOT_W-1:0]     slot;
   slab_entry_type        cur;
   logic [LIM_W-1:0]      base_ext;
   logic [LIM_W-1:0]      hdr_end;
   logic [LIM_W-1:0]      limit;
   logic [LIM_W-1:0]      a_ext;
   logic [DIV_W:0]        free_idx;
   logic [IDX_W-1:0]      chain_pos;
   logic                  cfg_wr;

   // The effective block size is at least one pointer.
   assign eff_sz = (block_bytes_ff > SZ_W'(PTR_BYTES)) ? block_bytes_ff : SZ_W'(PTR_BYTES);

   // The search counter runs from the slab count down to one; the slot is one below.
   assign slot = SLOT_W'(kcnt_ff - SCNT_W'(1));
   assign cur  = slab_tab[slot];

   assign base_ext = LIM_W'(cur.base);
   assign hdr_end  = base_ext + LIM_W'(HEADER_BYTES);
   assign limit    = hdr_end + LIM_W'(prod_ff);
   assign a_ext    = LIM_W'(addr_ff);
   assign free_idx = (DIV_W+1)'(cur.first) + (DIV_W+1)'(dvd_ff);
   assign chain_pos = IDX_W'(cur.first) + IDX_W'(chain_ff);

   assign rem_sh   = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, eff_sz};
   assign rem_diff = rem_sh - {1'b0, eff_sz};

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_BLOCK_BYTES);

   always_comb begin
      state_in       = state_ff;
      block_bytes_in = block_bytes_ff;
      slab_count_in  = slab_count_ff;
      blocks_used_in = blocks_used_ff;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      len_in         = len_ff;
      kcnt_in        = kcnt_ff;
      chain_in       = chain_ff;
      grow_n_in      = grow_n_ff;
      prod_in        = prod_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      dcnt_in        = dcnt_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      tab_we         = 1'b0;
      tab_wslot      = slot;
      tab_wdata      = cur;
      mem_we         = 1'b0;
      mem_waddr      = chain_pos;
      mem_wdata      = chain_pos;
      mem_raddr      = cur.head;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = cmd_type'(req_cmd);
               addr_in       = req_address;
               len_in        = req_length;
               kcnt_in       = slab_count_ff;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               case (cmd_type'(req_cmd))
                  CMD_GROW: begin
                     state_in = S_GROW_CHK;
                  end
                  CMD_ALLOC: begin
                     if (slab_count_ff == '0) begin
                        res_status_in = ST_OOM;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_FREE: begin
                     if (req_address == '0) begin
                        state_in = S_DONE;
                     end else if (slab_count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_GROW_CHK: begin
            if ((LEN_W+1)'(len_ff) < (LEN_W+1)'(HEADER_BYTES) + (LEN_W+1)'(eff_sz)) begin
               res_status_in = ST_TOO_SMALL;
               state_in      = S_DONE;
            end else if (slab_count_ff >= SCNT_W'(MAX_SLABS)) begin
               res_status_in = ST_TABLE_FULL;
               state_in      = S_DONE;
            end else begin
               dvd_in   = DIV_W'(len_ff - LEN_W'(HEADER_BYTES));
               rem_in   = '0;
               dcnt_in  = DCNT_W'(DIV_W);
               state_in = S_GROW_DIV;
            end
         end

         S_GROW_DIV: begin
            rem_in  = rem_ge ? SZ_W'(rem_diff) : SZ_W'(rem_sh);
            dvd_in  = {dvd_ff[DIV_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               // The quotient is complete in the dividend register next cycle,
               // so the capacity check uses the value being loaded.
               if ({dvd_ff[DIV_W-2:0], rem_ge} >
                   DIV_W'(MAX_BLOCKS) - DIV_W'(blocks_used_ff)) begin
                  res_status_in = ST_TABLE_FULL;
                  state_in      = S_DONE;
               end else begin
                  grow_n_in          = BCNT_W'({dvd_ff[DIV_W-2:0], rem_ge});
                  tab_we             = 1'b1;
                  tab_wslot          = SLOT_W'(slab_count_ff);
                  tab_wdata.base     = addr_ff;
                  tab_wdata.total    = BCNT_W'({dvd_ff[DIV_W-2:0], rem_ge});
                  tab_wdata.free_cnt = BCNT_W'({dvd_ff[DIV_W-2:0], rem_ge});
                  tab_wdata.first    = IDX_W'(blocks_used_ff);
                  tab_wdata.head     = IDX_W'(blocks_used_ff);
                  kcnt_in            = slab_count_ff + SCNT_W'(1);
                  chain_in           = '0;
                  state_in           = S_GROW_CHAIN;
               end
            end
         end

         S_GROW_CHAIN: begin
            // One link per cycle, in address order; the last block links
            // back to the first.
            mem_we    = 1'b1;
            mem_waddr = chain_pos;
            if (chain_ff + BCNT_W'(1) == grow_n_ff) begin
               mem_wdata      = cur.first;
               blocks_used_in = blocks_used_ff + grow_n_ff;
               slab_count_in  = slab_count_ff + SCNT_W'(1);
               state_in       = S_DONE;
            end else begin
               mem_wdata = chain_pos + IDX_W'(1);
               chain_in  = chain_ff + BCNT_W'(1);
            end
         end

         S_SEARCH: begin
            prod_in  = PROD_W'(eff_sz) * PROD_W'(cur.total);
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (cur.free_cnt != '0) begin
                  mem_raddr = cur.head;
                  state_in  = S_ALLOC_RD;
               end else if (kcnt_ff == SCNT_W'(1)) begin
                  res_status_in = ST_OOM;
                  state_in      = S_DONE;
               end else begin
                  kcnt_in  = kcnt_ff - SCNT_W'(1);
                  state_in = S_SEARCH;
               end
            end else begin
               if (a_ext > base_ext && a_ext < limit) begin
                  if (a_ext < hdr_end) begin
                     res_status_in = ST_MISALIGNED;
                     state_in      = S_DONE;
                  end else begin
                     dvd_in   = DIV_W'(a_ext - hdr_end);
                     rem_in   = '0;
                     dcnt_in  = DCNT_W'(DIV_W);
                     state_in = S_FREE_DIV;
                  end
               end else if (kcnt_ff == SCNT_W'(1)) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  kcnt_in  = kcnt_ff - SCNT_W'(1);
                  state_in = S_SEARCH;
               end
            end
         end

         S_ALLOC_RD: begin
            // Pop the head: the link read last cycle becomes the new head.
            prod_in            = PROD_W'(eff_sz) * PROD_W'(cur.head - cur.first);
            tab_we             = 1'b1;
            tab_wdata.head     = link_rdata_ff;
            tab_wdata.free_cnt = cur.free_cnt - BCNT_W'(1);
            state_in           = S_ALLOC_ADD;
         end

         S_ALLOC_ADD: begin
            res_addr_in = cur.base + ADDR_W'(HEADER_BYTES) + ADDR_W'(prod_ff);
            state_in    = S_DONE;
         end

         S_FREE_DIV: begin
            rem_in  = rem_ge ? SZ_W'(rem_diff) : SZ_W'(rem_sh);
            dvd_in  = {dvd_ff[DIV_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_FREE_UPD;
            end
         end

         S_FREE_UPD: begin
            if (rem_ff != '0) begin
               res_status_in = ST_MISALIGNED;
            end else if (cur.free_cnt >= cur.total) begin
               res_status_in = ST_OVER_FREE;
            end else if (free_idx >= (DIV_W+1)'(MAX_BLOCKS)) begin
               res_status_in = ST_NOT_FOUND;
            end else begin
               // Push the block: it links to the old head and becomes the head.
               mem_we             = 1'b1;
               mem_waddr          = IDX_W'(free_idx);
               mem_wdata          = cur.head;
               tab_we             = 1'b1;
               tab_wdata.head     = IDX_W'(free_idx);
               tab_wdata.free_cnt = cur.free_cnt + BCNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A block size write discards every slab.
      if (cfg_wr) begin
         block_bytes_in = csr_pwdata[SZ_W-1:0];
         slab_count_in  = '0;
         blocks_used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         block_bytes_ff <= SZ_W'(PTR_BYTES);
         slab_count_ff  <= '0;
         blocks_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_bytes_ff <= block_bytes_in;
         slab_count_ff  <= slab_count_in;
         blocks_used_ff <= blocks_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      kcnt_ff       <= kcnt_in;
      chain_ff      <= chain_in;
      grow_n_ff     <= grow_n_in;
      prod_ff       <= prod_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Slab table write port.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         slab_tab[tab_wslot] <= tab_wdata;
      end
   end

   // Link memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      link_rdata_ff <= link_mem[mem_raddr];
   end

   // A new transaction is taken only when the sequencer is idle.
   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BLOCK_BYTES) ?
                       {{(32-SZ_W){1'b0}}, block_bytes_ff} : '0;

`ifndef NO_ASSERTIONS
   // Every transaction that is taken keeps the sequencer busy, so no two are accepted back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("allocator accepted back-to-back transactions");

   // Only a successful alloc reports a nonzero block address.
   a_addr_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_block_address == '0))
      else $error("nonzero block address with an error status");

   // The slab and block bookkeeping never exceeds the table sizes.
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (slab_count_ff <= SCNT_W'(MAX_SLABS)) && (blocks_used_ff <= BCNT_W'(MAX_BLOCKS)))
      else $error("slab or block count out of range");
`endif

endmodule

`default_nettype wire
